[rtl/core/mlf_pkg.sv]
// shared types, codes and constants of the midi learn filter controller
package mlf_pkg;

  // default depths of the request queues
  localparam int ITEM_DEPTH_DEF   = 2;
  localparam int RESULT_DEPTH_DEF = 2;

  // double press window in milliseconds
  localparam logic [31:0] PRESS_WINDOW_MS = 32'd1000;

  // full filter after a clear
  localparam logic [15:0] MASK_ALL  = 16'hFFFF;
  localparam logic [7:0]  NOTE_BOT  = 8'd0;
  localparam logic [7:0]  NOTE_TOP  = 8'd255;

  // status nibble codes
  localparam logic [3:0] CMD_NOTE_OFF = 4'd8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'd9;
  localparam logic [3:0] CMD_CHAN_LO  = 4'd8;
  localparam logic [3:0] CMD_CHAN_HI  = 4'd14;

  // input action codes
  typedef enum logic [1:0] {
    ACT_MIDI  = 2'd0,
    ACT_LINK  = 2'd1,
    ACT_PRESS = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // route codes
  typedef enum logic [1:0] {
    ROUTE_DROP  = 2'd0,
    ROUTE_THRU  = 2'd1,
    ROUTE_SYNTH = 2'd2,
    ROUTE_TRIG  = 2'd3
  } route_t;

  // link command codes
  typedef enum logic [1:0] {
    LINK_NONE   = 2'd0,
    LINK_DETECT = 2'd1,
    LINK_ABORT  = 2'd2,
    LINK_RSVD   = 2'd3
  } link_t;

  // operation modes
  localparam logic [1:0] OPM_THRU  = 2'd0;
  localparam logic [1:0] OPM_SYNTH = 2'd1;
  localparam logic [1:0] OPM_TRIG  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OP_MODE   = 2'd0;
  localparam logic [1:0] CFG_INIT_MASK = 2'd1;
  localparam logic [1:0] CFG_INIT_MIN  = 2'd2;
  localparam logic [1:0] CFG_INIT_MAX  = 2'd3;

  // input request
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  command;
    logic [3:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic        usb_present;
    logic        bus_present;
    logic [31:0] time_ms;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [1:0]  route;
    logic        all_notes_off;
    logic        store_request;
    logic [1:0]  link_command;
    logic [2:0]  mode_state;
    logic [15:0] mask_out;
    logic [7:0]  low_note_out;
    logic [7:0]  high_note_out;
    logic        range_learned;
  } out_req_t;

  // classified item between front and back
  typedef struct packed {
    action_t     action;
    logic        chmsg;
    logic        notemsg;
    logic [15:0] chan_bit;
    logic [7:0]  note;
    logic        usb;
    logic        bus;
    logic [31:0] time_ms;
  } item_t;

endpackage

[rtl/core/mlf_queue.sv]
// small register queue used between the front, the back and the result port
module mlf_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  // status and head
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/core/mlf_front.sv]
// front end: decodes an input request into a classified item
module mlf_front (
  input  mlf_pkg::in_req_t in_req,
  output mlf_pkg::item_t   item
);
  import mlf_pkg::*;

  // message class and channel one-hot
  always_comb begin
    item.action  = action_t'(in_req.action);
    item.chmsg   = (in_req.command >= CMD_CHAN_LO) && (in_req.command <= CMD_CHAN_HI);
    item.notemsg = (in_req.command == CMD_NOTE_OFF) || (in_req.command == CMD_NOTE_ON);
    item.chan_bit = 16'd1 << in_req.channel;
    item.note    = in_req.data_first;
    item.usb     = in_req.usb_present;
    item.bus     = in_req.bus_present;
    item.time_ms = in_req.time_ms;
  end

endmodule

[rtl/core/mlf_back.sv]
// back end: link mode state machine, learn filter and routing decision
module mlf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  mlf_pkg::item_t     item,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output mlf_pkg::out_req_t  result
);
  import mlf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_ERROR  = 3'd1,
    ST_NORMAL = 3'd2,
    ST_LCLEAR = 3'd3,
    ST_LEARN  = 3'd4
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  op_mode_r, op_mode_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        widened_r, widened_nxt;
  logic        usb_master_r, usb_master_nxt;
  logic [31:0] last_press_r, last_press_nxt;

  route_t      route, note_rt;
  link_t       link;
  logic        notes_off, store;
  logic        in_mask, in_range;
  logic [31:0] press_gap;
  logic        double_press;

  // shared decisions
  always_comb begin
    unique case (op_mode_r)
      OPM_SYNTH: note_rt = ROUTE_SYNTH;
      OPM_TRIG:  note_rt = ROUTE_TRIG;
      default:   note_rt = ROUTE_DROP;
    endcase
  end
  assign in_mask      = |(mask_r & item.chan_bit);
  assign in_range     = (item.note >= low_r) && (item.note <= high_r);
  assign press_gap    = item.time_ms - last_press_r;
  assign double_press = (last_press_r != '0) && (press_gap < PRESS_WINDOW_MS);

  // next state and result
  always_comb begin
    state_nxt      = state_r;
    op_mode_nxt    = op_mode_r;
    mask_nxt       = mask_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    widened_nxt    = widened_r;
    usb_master_nxt = usb_master_r;
    last_press_nxt = last_press_r;
    route          = ROUTE_DROP;
    link           = LINK_NONE;
    notes_off      = 1'b0;
    store          = 1'b0;

    if (step) begin
      unique case (item.action)
        // link status change
        ACT_LINK: begin
          if (item.usb ^ item.bus) begin
            if (item.usb) begin
              link           = LINK_DETECT;
              usb_master_nxt = 1'b1;
            end
            state_nxt = ST_NORMAL;
          end else if (!item.usb) begin
            if (usb_master_r) begin
              link = LINK_ABORT;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ERROR;
          end
          notes_off = 1'b1;
        end

        // learn button
        ACT_PRESS: begin
          if (state_r == ST_NORMAL) begin
            if (double_press) begin
              mask_nxt    = MASK_ALL;
              low_nxt     = NOTE_BOT;
              high_nxt    = NOTE_TOP;
              widened_nxt = 1'b0;
            end
            last_press_nxt = item.time_ms;
            notes_off      = 1'b1;
            state_nxt      = ST_LCLEAR;
          end else if (state_r == ST_LCLEAR || state_r == ST_LEARN) begin
            if (state_r == ST_LEARN && op_mode_r == OPM_SYNTH && low_r == high_r) begin
              low_nxt  = NOTE_BOT;
              high_nxt = NOTE_TOP;
            end
            store     = 1'b1;
            notes_off = 1'b1;
            state_nxt = ST_NORMAL;
          end
        end

        // midi event
        ACT_MIDI: begin
          if (state_r == ST_NORMAL) begin
            if (item.chmsg) begin
              if (in_mask) begin
                if (op_mode_r == OPM_THRU) begin
                  route = ROUTE_THRU;
                end else if (item.notemsg && in_range) begin
                  route = note_rt;
                end
              end
            end else if (op_mode_r == OPM_THRU) begin
              route = ROUTE_THRU;
            end
          end else if (state_r == ST_LCLEAR) begin
            mask_nxt    = MASK_ALL;
            low_nxt     = NOTE_BOT;
            high_nxt    = NOTE_TOP;
            widened_nxt = 1'b0;
            notes_off   = 1'b1;
            if (op_mode_r == OPM_THRU && item.chmsg) begin
              mask_nxt  = item.chan_bit;
              route     = ROUTE_THRU;
              state_nxt = ST_LEARN;
            end else if (item.notemsg) begin
              low_nxt   = item.note;
              high_nxt  = item.note;
              mask_nxt  = item.chan_bit;
              route     = note_rt;
              state_nxt = ST_LEARN;
            end
          end else if (state_r == ST_LEARN) begin
            if (op_mode_r == OPM_THRU && item.chmsg) begin
              if (!in_mask) begin
                mask_nxt    = mask_r | item.chan_bit;
                widened_nxt = 1'b1;
              end
              route = ROUTE_THRU;
            end else if (item.notemsg) begin
              if (in_mask && !in_range) begin
                if (item.note < low_r) begin
                  low_nxt = item.note;
                end
                if (item.note > high_r) begin
                  high_nxt = item.note;
                end
                widened_nxt = 1'b1;
              end
              route = note_rt;
            end
          end
        end

        default: begin
        end
      endcase
    end else if (cfg_write) begin
      // register writes also load the live filter
      unique case (cfg_index)
        CFG_OP_MODE:   op_mode_nxt = cfg_data[1:0];
        CFG_INIT_MASK: mask_nxt    = cfg_data;
        CFG_INIT_MIN:  low_nxt     = cfg_data[7:0];
        CFG_INIT_MAX:  high_nxt    = cfg_data[7:0];
        default: begin
        end
      endcase
    end

    result.route         = route;
    result.all_notes_off = notes_off;
    result.store_request = store;
    result.link_command  = link;
    result.mode_state    = state_nxt;
    result.mask_out      = mask_nxt;
    result.low_note_out  = low_nxt;
    result.high_note_out = high_nxt;
    result.range_learned = widened_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_mode_r    <= OPM_THRU;
      mask_r       <= MASK_ALL;
      low_r        <= NOTE_BOT;
      high_r       <= NOTE_TOP;
      widened_r    <= 1'b0;
      usb_master_r <= 1'b0;
      last_press_r <= '0;
    end else begin
      state_r      <= state_nxt;
      op_mode_r    <= op_mode_nxt;
      mask_r       <= mask_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      widened_r    <= widened_nxt;
      usb_master_r <= usb_master_nxt;
      last_press_r <= last_press_nxt;
    end
  end

endmodule

[rtl/core/midi_learn_filter_controller.sv]
// top level of the midi learn filter controller
//
//   port group   direction   handshake          payload
//   in_          in          in_push / in_full  in_req  (action, command, channel, ...)
//   out_         out         out_pop / out_empty out_req (route, pulses, filter)
//   cfg_         in          cfg_valid / cfg_ready cfg_index, cfg_data
//
// one request per cycle sustained while the result queue has room; a request is held
// in the item queue, then the back end writes its result to the result queue (out_req).
// the back end's single state update sets that rate: it retires one item a cycle
// whenever the result queue has room. stalls on out_pop back up into in_full.
// synchronous active-low reset returns the filter to the full mask and range.
// cfg_ready is always high; the user must write only while no request is in flight, as the block leaves that unchecked.
module midi_learn_filter_controller #(
  parameter int ITEM_DEPTH   = mlf_pkg::ITEM_DEPTH_DEF,
  parameter int RESULT_DEPTH = mlf_pkg::RESULT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  mlf_pkg::in_req_t  in_req,
  output logic              out_empty,
  input  logic              out_pop,
  output mlf_pkg::out_req_t out_req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import mlf_pkg::*;

  item_t    front_item;
  item_t    head_item;
  logic     item_empty;
  logic     result_full;
  logic     step;
  out_req_t result;

  assign cfg_ready = 1'b1;
  assign step      = ~item_empty & ~result_full;

  // classify incoming requests
  mlf_front u_front (
    .in_req (in_req),
    .item   (front_item)
  );

  // queue between front and back
  mlf_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_item),
    .full  (in_full),
    .pop   (step),
    .dout  (head_item),
    .empty (item_empty)
  );

  // execute items against the filter state
  mlf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (head_item),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // result queue toward the consumer
  mlf_queue #(
    .WIDTH ($bits(out_req_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step),
    .din   (result),
    .full  (result_full),
    .pop   (out_pop),
    .dout  (out_req),
    .empty (out_empty)
  );

endmodule

[tb/midi_learn_filter_controller_tb.sv]
// self-checking testbench of the midi learn filter controller
`timescale 1ns / 1ps

module midi_learn_filter_controller_tb;
  import mlf_pkg::*;

  // link mode codes as seen on mode_state
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ERROR  = 3'd1;
  localparam logic [2:0] ST_NORMAL = 3'd2;
  localparam logic [2:0] ST_LCLEAR = 3'd3;
  localparam logic [2:0] ST_LEARN  = 3'd4;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 160;
  localparam int HOLD_CYCLES   = 250;
  localparam int SHOW_LIMIT    = 10;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  logic        in_full;
  in_req_t     in_req    = '0;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  out_req_t    out_req;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  midi_learn_filter_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_req   (out_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predicted controller state and settings
  logic [1:0]  op_mode     = OPM_THRU;
  logic [2:0]  ctl_state   = ST_IDLE;
  logic [15:0] flt_mask    = MASK_ALL;
  logic [7:0]  flt_lo      = NOTE_BOT;
  logic [7:0]  flt_hi      = NOTE_TOP;
  logic        flt_wide    = 1'b0;
  logic        usb_master  = 1'b0;
  logic [31:0] press_stamp = '0;

  // results still owed by the block, oldest first
  out_req_t    result_q[$];

  int          fault_cnt = 0;
  int          shown_cnt = 0;
  int          cycle_cnt = 0;
  int          tx_calm   = 0;
  int          rx_calm   = 0;
  int          rx_gap    = 0;
  int          hold_left = 0;
  int          rx_pick;
  logic        hold_token = 1'b0;
  logic        hold_seen  = 1'b0;
  logic [31:0] press_clock = '0;

  // directed plan: a request, or a register write between requests
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [15:0] val;
    in_req_t     req;
    bit          fixed;
    out_req_t    want;
  } plan_row_t;

  plan_row_t plan_q[$];

  function automatic void plan_item(input in_req_t r);
    plan_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, req: r, fixed: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_fixed(input in_req_t r, input out_req_t w);
    plan_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, req: r, fixed: 1'b1, want: w};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_cfg(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, req: '0, fixed: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic in_req_t item_of(input logic [1:0] act, input logic [3:0] cmd,
                                      input logic [3:0] ch, input logic [7:0] d1,
                                      input logic [7:0] d2, input logic usb,
                                      input logic bus, input logic [31:0] t);
    in_req_t r;
    r.action      = act;
    r.command     = cmd;
    r.channel     = ch;
    r.data_first  = d1;
    r.data_second = d2;
    r.usb_present = usb;
    r.bus_present = bus;
    r.time_ms     = t;
    return r;
  endfunction

  function automatic out_req_t outcome_of(input logic [1:0] rt, input logic off,
                                          input logic sto, input logic [1:0] lk,
                                          input logic [2:0] st, input logic [15:0] m,
                                          input logic [7:0] lo, input logic [7:0] hi,
                                          input logic wide);
    out_req_t o;
    o.route         = rt;
    o.all_notes_off = off;
    o.store_request = sto;
    o.link_command  = lk;
    o.mode_state    = st;
    o.mask_out      = m;
    o.low_note_out  = lo;
    o.high_note_out = hi;
    o.range_learned = wide;
    return o;
  endfunction

  // route a passing note takes in the current operation mode
  function automatic logic [1:0] note_route();
    if (op_mode == OPM_SYNTH) return ROUTE_SYNTH;
    if (op_mode == OPM_TRIG) return ROUTE_TRIG;
    return ROUTE_DROP;
  endfunction

  function automatic void reset_filter();
    flt_mask = MASK_ALL;
    flt_lo   = NOTE_BOT;
    flt_hi   = NOTE_TOP;
    flt_wide = 1'b0;
  endfunction

  // next controller state and the result of one accepted request
  task automatic predict_result(input in_req_t r, output out_req_t o);
    logic [15:0] chan_bit;
    logic        chan_msg;
    logic        note_msg;
    logic [31:0] since;
    logic [1:0]  rt;
    logic [1:0]  lk;
    logic        off;
    logic        sto;
    chan_bit = 16'd1 << r.channel;
    chan_msg = (r.command >= CMD_CHAN_LO) && (r.command <= CMD_CHAN_HI);
    note_msg = (r.command == CMD_NOTE_OFF) || (r.command == CMD_NOTE_ON);
    since    = r.time_ms - press_stamp;
    rt       = ROUTE_DROP;
    lk       = LINK_NONE;
    off      = 1'b0;
    sto      = 1'b0;
    case (r.action)
      ACT_LINK: begin
        // exactly one side present means normal; detect only for usb
        if (r.usb_present ^ r.bus_present) begin
          if (r.usb_present) begin
            lk         = LINK_DETECT;
            usb_master = 1'b1;
          end
          ctl_state = ST_NORMAL;
        end else if (!r.usb_present) begin
          if (usb_master) lk = LINK_ABORT;
          ctl_state = ST_IDLE;
        end else begin
          ctl_state = ST_ERROR;
        end
        off = 1'b1;
      end
      ACT_PRESS: begin
        if (ctl_state == ST_NORMAL) begin
          // double press inside the window clears the filter
          if (press_stamp != 0 && since < PRESS_WINDOW_MS) reset_filter();
          press_stamp = r.time_ms;
          off         = 1'b1;
          ctl_state   = ST_LCLEAR;
        end else if (ctl_state == ST_LCLEAR || ctl_state == ST_LEARN) begin
          // a single learned synth note opens the whole range again
          if (ctl_state == ST_LEARN && op_mode == OPM_SYNTH && flt_lo == flt_hi) begin
            flt_lo = NOTE_BOT;
            flt_hi = NOTE_TOP;
          end
          sto       = 1'b1;
          off       = 1'b1;
          ctl_state = ST_NORMAL;
        end
      end
      ACT_MIDI: begin
        if (ctl_state == ST_NORMAL) begin
          if (chan_msg) begin
            if ((flt_mask & chan_bit) != 0) begin
              if (op_mode == OPM_THRU) begin
                rt = ROUTE_THRU;
              end else if (note_msg && r.data_first >= flt_lo && r.data_first <= flt_hi) begin
                rt = note_route();
              end
            end
          end else if (op_mode == OPM_THRU) begin
            rt = ROUTE_THRU;
          end
        end else if (ctl_state == ST_LCLEAR) begin
          // any message clears the filter; the first thru channel message or note seeds it
          reset_filter();
          off = 1'b1;
          if (op_mode == OPM_THRU && chan_msg) begin
            flt_mask  = chan_bit;
            rt        = ROUTE_THRU;
            ctl_state = ST_LEARN;
          end else if (note_msg) begin
            flt_lo    = r.data_first;
            flt_hi    = r.data_first;
            flt_mask  = chan_bit;
            rt        = note_route();
            ctl_state = ST_LEARN;
          end
        end else if (ctl_state == ST_LEARN) begin
          // later messages only widen mask or range
          if (op_mode == OPM_THRU && chan_msg) begin
            if ((flt_mask & chan_bit) == 0) begin
              flt_mask = flt_mask | chan_bit;
              flt_wide = 1'b1;
            end
            rt = ROUTE_THRU;
          end else if (note_msg) begin
            if ((flt_mask & chan_bit) != 0 &&
                (r.data_first < flt_lo || r.data_first > flt_hi)) begin
              if (r.data_first < flt_lo) flt_lo = r.data_first;
              if (r.data_first > flt_hi) flt_hi = r.data_first;
              flt_wide = 1'b1;
            end
            rt = note_route();
          end
        end
      end
      default: ;
    endcase
    o = outcome_of(rt, off, sto, lk, ctl_state, flt_mask, flt_lo, flt_hi, flt_wide);
  endtask

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random request, weighted toward link-up, learn sequences and notes
  function automatic in_req_t random_request();
    in_req_t r;
    int      pick;
    int      sub;
    r.action      = ACT_MIDI;
    r.command     = 4'($urandom_range(0, 15));
    r.channel     = 4'($urandom_range(0, 15));
    r.data_first  = 8'($urandom_range(0, 255));
    r.data_second = 8'($urandom_range(0, 255));
    r.usb_present = 1'($urandom_range(0, 1));
    r.bus_present = 1'($urandom_range(0, 1));
    r.time_ms     = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.action = ACT_LINK;
      sub = $urandom_range(0, 99);
      if (sub < 75) begin
        r.bus_present = ~r.usb_present;
      end else if (sub < 87) begin
        r.usb_present = 1'b0;
        r.bus_present = 1'b0;
      end else begin
        r.usb_present = 1'b1;
        r.bus_present = 1'b1;
      end
    end else if (pick < 17) begin
      r.action = ACT_PRESS;
      sub = $urandom_range(0, 99);
      if (sub < 65) press_clock = press_clock + $urandom_range(0, 1400);
      else if (sub < 80) press_clock = press_clock + $urandom_range(0, 60);
      else if (sub < 88) press_clock = $urandom;
      else if (sub < 94) press_clock = '0;
      else press_clock = 32'hFFFF_FFFF - $urandom_range(0, 500);
      r.time_ms = press_clock;
    end else if (pick < 20) begin
      r.action = ACT_NONE;
    end else begin
      sub = $urandom_range(0, 99);
      if (sub < 60) r.command = $urandom_range(0, 1) ? CMD_NOTE_ON : CMD_NOTE_OFF;
      else if (sub < 85) r.command = 4'($urandom_range(10, 14));
      if ($urandom_range(0, 99) < 60) r.channel = 4'($urandom_range(0, 3));
      sub = $urandom_range(0, 99);
      if (sub < 40) r.data_first = 8'($urandom_range(30, 90));
      else if (sub < 50) r.data_first = 8'd0;
      else if (sub < 60) r.data_first = 8'd255;
    end
    return r;
  endfunction

  // offer one request, wait for it to be taken, then predict its result
  task automatic send_request(input in_req_t r, input bit fixed, input out_req_t want);
    int       gap;
    out_req_t pred;
    gap = pick_pause(tx_calm);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req  <= r;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_result(r, pred);
    result_q.push_back(fixed ? want : pred);
  endtask

  // stop offering and let every owed result come out
  task automatic settle_requests();
    in_push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    settle_requests();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // initial values also load the live filter
    case (idx)
      CFG_OP_MODE:   op_mode  = val[1:0];
      CFG_INIT_MASK: flt_mask = val;
      CFG_INIT_MIN:  flt_lo   = val[7:0];
      CFG_INIT_MAX:  flt_hi   = val[7:0];
      default: ;
    endcase
  endtask

  // result side: random pops, one long hold on request, checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (result_q.size() == 0) begin
          fault_cnt = fault_cnt + 1;
          if (shown_cnt < SHOW_LIMIT) begin
            shown_cnt = shown_cnt + 1;
            $display("unexpected result: route=%0d mode=%0d mask=%h",
                     out_req.route, out_req.mode_state, out_req.mask_out);
          end
        end else if (out_req.route !== result_q[0].route ||
                     out_req.all_notes_off !== result_q[0].all_notes_off ||
                     out_req.store_request !== result_q[0].store_request ||
                     out_req.link_command !== result_q[0].link_command ||
                     out_req.mode_state !== result_q[0].mode_state ||
                     out_req.mask_out !== result_q[0].mask_out ||
                     out_req.low_note_out !== result_q[0].low_note_out ||
                     out_req.high_note_out !== result_q[0].high_note_out ||
                     out_req.range_learned !== result_q[0].range_learned) begin
          fault_cnt = fault_cnt + 1;
          if (shown_cnt < SHOW_LIMIT) begin
            shown_cnt = shown_cnt + 1;
            $display("mismatch exp: route=%0d off=%0d store=%0d link=%0d mode=%0d %h %0d..%0d w=%0d",
                     result_q[0].route, result_q[0].all_notes_off,
                     result_q[0].store_request, result_q[0].link_command,
                     result_q[0].mode_state, result_q[0].mask_out,
                     result_q[0].low_note_out, result_q[0].high_note_out,
                     result_q[0].range_learned);
            $display("         got: route=%0d off=%0d store=%0d link=%0d mode=%0d %h %0d..%0d w=%0d",
                     out_req.route, out_req.all_notes_off, out_req.store_request,
                     out_req.link_command, out_req.mode_state, out_req.mask_out,
                     out_req.low_note_out, out_req.high_note_out, out_req.range_learned);
          end
        end
        if (result_q.size() != 0) void'(result_q.pop_front());
      end
      // pop pacing
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        out_pop   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_pop   <= 1'b0;
      end else if (out_pop && !out_empty) begin
        rx_pick = pick_pause(rx_calm);
        if (rx_pick == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          rx_gap  <= rx_pick - 1;
        end
      end else if (rx_gap != 0) begin
        rx_gap  <= rx_gap - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("midi_learn_filter_controller_tb NOT OK");
      $finish;
    end
  end

  // stimulus
  initial begin
    out_req_t base;
    in_req_t  r;
    int       counted;
    base = outcome_of(ROUTE_DROP, 1'b0, 1'b0, LINK_NONE, ST_IDLE, MASK_ALL,
                      NOTE_BOT, NOTE_TOP, 1'b0);

    // ignored while idle: midi, unknown action, press
    plan_fixed(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd0, 8'd60, 8'd255, 1'b0, 1'b0, 32'd0), base);
    plan_fixed(item_of(ACT_NONE, 4'hF, 4'hF, 8'hFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF),
               base);
    plan_fixed(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd123), base);
    // both sides present is an error, midi is ignored there
    plan_fixed(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b1, 1'b1, 32'd0),
               outcome_of(ROUTE_DROP, 1'b1, 1'b0, LINK_NONE, ST_ERROR, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    plan_fixed(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd0, 8'd60, 8'd64, 1'b0, 1'b0, 32'd0),
               outcome_of(ROUTE_DROP, 1'b0, 1'b0, LINK_NONE, ST_ERROR, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    // no side: idle, no abort since usb never led
    plan_fixed(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0),
               outcome_of(ROUTE_DROP, 1'b1, 1'b0, LINK_NONE, ST_IDLE, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    // bus only: normal without detect
    plan_fixed(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'd0),
               outcome_of(ROUTE_DROP, 1'b1, 1'b0, LINK_NONE, ST_NORMAL, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    // thru mode passes the top note and system messages
    plan_fixed(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd15, 8'd255, 8'd0, 1'b0, 1'b0, 32'd0),
               outcome_of(ROUTE_THRU, 1'b0, 1'b0, LINK_NONE, ST_NORMAL, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    plan_fixed(item_of(ACT_MIDI, 4'hF, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0),
               outcome_of(ROUTE_THRU, 1'b0, 1'b0, LINK_NONE, ST_NORMAL, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    // usb only: normal with detect
    plan_fixed(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b1, 1'b0, 32'd0),
               outcome_of(ROUTE_DROP, 1'b1, 1'b0, LINK_DETECT, ST_NORMAL, MASK_ALL,
                          NOTE_BOT, NOTE_TOP, 1'b0));
    // thru learn: seed with one channel, widen with another, store
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_MIDI, 4'hB, 4'd3, 8'd7, 8'd100, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_MIDI, 4'hE, 4'd12, 8'd0, 8'd64, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd1));
    // presses: far apart, then a double press across the counter wrap
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd5000));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd5001));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFF0));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0000_0100));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    // link lost after usb led: abort
    plan_item(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    // synth gate with a one-note range on channel zero
    plan_cfg(CFG_OP_MODE, {14'd0, OPM_SYNTH});
    plan_cfg(CFG_INIT_MASK, 16'h0001);
    plan_cfg(CFG_INIT_MIN, 16'd40);
    plan_cfg(CFG_INIT_MAX, 16'd40);
    plan_item(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'd0));
    plan_item(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd0, 8'd40, 8'd90, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd0, 8'd41, 8'd90, 1'b0, 1'b0, 32'd0));
    // learn one synth note, then leaving learn reopens the range
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd100));
    plan_item(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd2, 8'd60, 8'd90, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    // trigger mode with an inverted range, then learn and widen
    plan_cfg(CFG_OP_MODE, {14'd0, OPM_TRIG});
    plan_cfg(CFG_INIT_MASK, MASK_ALL);
    plan_cfg(CFG_INIT_MIN, 16'd255);
    plan_cfg(CFG_INIT_MAX, 16'd0);
    plan_item(item_of(ACT_LINK, 4'd0, 4'd0, 8'd0, 8'd0, 1'b1, 1'b0, 32'd0));
    plan_item(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd7, 8'd255, 8'd90, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_PRESS, 4'd0, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'd2000));
    plan_item(item_of(ACT_MIDI, CMD_NOTE_OFF, 4'd7, 8'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    plan_item(item_of(ACT_MIDI, CMD_NOTE_ON, 4'd7, 8'd255, 8'd255, 1'b0, 1'b0, 32'd0));

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < plan_q.size(); i++) begin
      if (plan_q[i].is_cfg) write_register(plan_q[i].idx, plan_q[i].val);
      else send_request(plan_q[i].req, plan_q[i].fixed, plan_q[i].want);
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_register(CFG_OP_MODE, {14'd0, OPM_THRU});
          write_register(CFG_INIT_MASK, MASK_ALL);
          write_register(CFG_INIT_MIN, 16'd0);
          write_register(CFG_INIT_MAX, 16'd255);
        end
        1: begin
          write_register(CFG_OP_MODE, {14'd0, OPM_SYNTH});
          write_register(CFG_INIT_MASK, 16'($urandom_range(0, 65535)));
          write_register(CFG_INIT_MIN, 16'($urandom_range(0, 100)));
          write_register(CFG_INIT_MAX, 16'($urandom_range(20, 127)));
          // long pop stall while requests keep coming
          hold_token <= ~hold_token;
        end
        2: begin
          write_register(CFG_OP_MODE, {14'd0, OPM_TRIG});
          write_register(CFG_INIT_MASK, 16'h0000);
          write_register(CFG_INIT_MIN, 16'($urandom_range(0, 255)));
          write_register(CFG_INIT_MAX, 16'd255);
        end
        3: begin
          // unused mode value, upper data bits set
          write_register(CFG_OP_MODE, {14'($urandom_range(0, 16383)), 2'd3});
          write_register(CFG_INIT_MASK, 16'($urandom_range(0, 65535)));
          write_register(CFG_INIT_MIN, 16'd0);
          write_register(CFG_INIT_MAX, 16'd0);
        end
        default: begin
          write_register(CFG_OP_MODE, {14'($urandom_range(0, 16383)), OPM_THRU});
          write_register(CFG_INIT_MASK, 16'($urandom_range(0, 65535)));
          write_register(CFG_INIT_MIN, {8'($urandom_range(0, 255)), 8'd0} | 16'(30));
          write_register(CFG_INIT_MAX, 16'($urandom_range(0, 65535)));
        end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = random_request();
        counted = counted + 1;
        send_request(r, 1'b0, '0);
      end
    end

    // drain and report
    settle_requests();
    repeat (20) @(posedge clk);
    if (fault_cnt == 0 && result_q.size() == 0) begin
      $display("midi_learn_filter_controller_tb OK");
    end else begin
      $display("midi_learn_filter_controller_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mlf_pkg.sv
rtl/core/mlf_queue.sv
rtl/core/mlf_front.sv
rtl/core/mlf_back.sv
rtl/core/midi_learn_filter_controller.sv
tb/midi_learn_filter_controller_tb.sv
